// ===== rtl/sfra_pkg.sv =====
// Types and constants shared by the step function range-add/min block.
package sfra_pkg;

    localparam int COORD_W = 31;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 12;

    localparam logic [1:0] ACT_QUERY = 2'd0;
    localparam logic [1:0] ACT_MIN   = 2'd1;
    localparam logic [1:0] ACT_ADD   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_EVAL, ST_ADD, ST_FIX_LO, ST_FIX_HI, ST_DONE
    } state_t;

    typedef enum logic [1:0] {OP_NOP, OP_ADD, OP_INS, OP_DEL} cell_op_t;

    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] coord;
        logic [VAL_W-1:0]   value;
    } entry_t;

    typedef struct packed {
        cell_op_t           op;
        logic [COORD_W-1:0] key;
        logic [VAL_W-1:0]   val;
        logic [COORD_W-1:0] lo;
        logic [COORD_W-1:0] hi;
        logic [COORD_W-1:0] lo1;
        logic [COORD_W-1:0] hi1;
        logic [VAL_W-1:0]   diff;
    } cmd_t;

    typedef struct packed {
        logic               active;
        logic [VAL_W-1:0]   vlo;
        logic [VAL_W-1:0]   vlo1;
        logic [VAL_W-1:0]   vhi;
        logic [VAL_W-1:0]   vhi1;
        logic [VAL_W-1:0]   vmin;
        logic               ex_lo;
        logic               ex_hi1;
        logic [CNT_W-1:0]   cnt;
    } acc_t;

endpackage

// ===== rtl/sfra_cell.sv =====
// One breakpoint cell of the sorted chain, with its stage of the scan pipeline.
module sfra_cell
    import sfra_pkg::*;
#(
    parameter bit ROOT = 1'b0
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  cmd_t   cmd,
    input  entry_t left_ent,
    input  entry_t right_ent,
    input  acc_t   acc_in,
    output entry_t ent,
    output acc_t   acc_out
);

    entry_t ent_reg, ent_next;
    acc_t   acc_reg, acc_next;

    always_comb begin
        ent_next = ent_reg;
        case (cmd.op)
            OP_ADD: begin
                if (ent_reg.valid && ent_reg.coord >= cmd.lo && ent_reg.coord <= cmd.hi) begin
                    ent_next.value = ent_reg.value + cmd.diff;
                end
            end
            OP_INS: begin
                if (left_ent.valid && left_ent.coord > cmd.key) begin
                    ent_next = left_ent;
                end else if (left_ent.valid && (!ent_reg.valid || ent_reg.coord > cmd.key)) begin
                    ent_next.valid = 1'b1;
                    ent_next.coord = cmd.key;
                    ent_next.value = cmd.val;
                end
            end
            OP_DEL: begin
                if (ent_reg.valid && ent_reg.coord >= cmd.key) begin
                    ent_next = right_ent;
                end
            end
            default: ent_next = ent_reg;
        endcase
    end

    always_comb begin
        acc_next = acc_in;
        if (ent_reg.valid) begin
            acc_next.cnt = acc_in.cnt + CNT_W'(1);
            if (ent_reg.coord <= cmd.lo) begin
                acc_next.vlo  = ent_reg.value;
                acc_next.vmin = ent_reg.value;
            end else if (ent_reg.coord <= cmd.hi
                         && $signed(ent_reg.value) < $signed(acc_in.vmin)) begin
                acc_next.vmin = ent_reg.value;
            end
            if (ent_reg.coord <= cmd.lo1) begin
                acc_next.vlo1 = ent_reg.value;
            end
            if (ent_reg.coord <= cmd.hi) begin
                acc_next.vhi = ent_reg.value;
            end
            if (ent_reg.coord <= cmd.hi1) begin
                acc_next.vhi1 = ent_reg.value;
            end
            if (ent_reg.coord == cmd.lo) begin
                acc_next.ex_lo = 1'b1;
            end
            if (ent_reg.coord == cmd.hi1) begin
                acc_next.ex_hi1 = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_reg <= '{valid: ROOT, coord: '0, value: '0};
            acc_reg <= '0;
        end else begin
            ent_reg <= ent_next;
            acc_reg <= acc_next;
        end
    end

    assign ent     = ent_reg;
    assign acc_out = acc_reg;

endmodule

// ===== rtl/step_function_range_add_min_core.sv =====
// Top level of the step function block: control sequencer and the breakpoint cell chain.
//
// The block holds a piecewise-constant function as a sorted row of 2*MAX_STEPS+1
// breakpoint cells. Items arrive on the s_ channel: tuser carries the action
// (point query, range minimum, range add) and tdata the fields lo, hi and diff.
// Each item yields exactly one result item on the m_ channel: tdata carries the
// function value or range minimum, and tuser the status flag that marks a range
// add rejected because the breakpoint store is full.
// One item is worked on at a time. A scan wavefront walks the chain one cell per
// cycle, so an item passes through the scan, then an evaluation step, then the
// update states ST_ADD, ST_FIX_LO and ST_FIX_HI for a range add, and then the
// result is loaded into the output register. The next item can be accepted in
// the cycle that the result becomes valid.
// The next item is accepted while a finished result still waits in the output
// register; if the receiver stalls, that next item completes and then holds
// until the output register is free.
// After reset the function is zero everywhere, with only the breakpoint at
// coordinate zero present, and both channels are idle.
module step_function_range_add_min_core
    import sfra_pkg::*;
#(
    parameter int MAX_STEPS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // lo[30:0], hi[61:31], diff[93:62], zero fill
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // result_value[31:0]
    output logic [0:0]  m_tuser    // status[0]
);

    localparam int CAP = 2 * MAX_STEPS + 1;

    state_t             state_reg, state_next;
    logic [1:0]         act_reg;
    logic [COORD_W-1:0] lo_reg, hi_reg;
    logic [VAL_W-1:0]   diff_reg;
    logic               go_reg;
    acc_t               res_acc_reg;
    logic               del_lo_reg, del_hi_reg;
    logic [VAL_W-1:0]   vlo_new_reg;
    logic [VAL_W-1:0]   result_reg;
    logic               status_reg;
    logic               m_tvalid_reg;
    logic [VAL_W-1:0]   m_data_reg;
    logic               m_stat_reg;

    logic [COORD_W-1:0] in_lo, in_hi;
    logic               top;
    logic [CNT_W-1:0]   free_cnt, need_cnt;
    logic               reject;
    logic [VAL_W-1:0]   eval_result;
    logic               eval_status;
    cmd_t               cmd;
    acc_t               acc_start;

    entry_t ents [CAP];
    acc_t   accs [CAP];

    assign in_lo = s_tdata[30:0];
    assign in_hi = (s_tdata[61:31] < s_tdata[30:0]) ? s_tdata[30:0] : s_tdata[61:31];
    assign top   = (hi_reg == {COORD_W{1'b1}});

    assign free_cnt = CNT_W'(CAP) - res_acc_reg.cnt;
    assign need_cnt = CNT_W'(!res_acc_reg.ex_lo) + CNT_W'(!top && !res_acc_reg.ex_hi1);
    assign reject   = free_cnt < need_cnt;

    always_comb begin
        acc_start        = '0;
        acc_start.active = go_reg;
    end

    always_comb begin
        state_next  = state_reg;
        eval_result = '0;
        eval_status = 1'b0;
        cmd         = '0;
        cmd.op      = OP_NOP;
        cmd.lo      = lo_reg;
        cmd.hi      = hi_reg;
        cmd.lo1     = lo_reg - COORD_W'(1);
        cmd.hi1     = hi_reg + COORD_W'(1);
        cmd.diff    = diff_reg;
        case (act_reg)
            ACT_QUERY: eval_result = res_acc_reg.vlo;
            ACT_MIN:   eval_result = res_acc_reg.vmin;
            ACT_ADD:   eval_status = (diff_reg != '0) && reject;
            default:   eval_result = '0;
        endcase
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (accs[CAP-1].active) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (act_reg == ACT_ADD && diff_reg != '0 && !reject) begin
                    state_next = ST_ADD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_ADD: begin
                cmd.op     = OP_ADD;
                state_next = ST_FIX_LO;
            end
            ST_FIX_LO: begin
                cmd.key = lo_reg;
                cmd.val = vlo_new_reg;
                if (res_acc_reg.ex_lo && del_lo_reg) begin
                    cmd.op = OP_DEL;
                end else if (!res_acc_reg.ex_lo && !del_lo_reg) begin
                    cmd.op = OP_INS;
                end
                state_next = ST_FIX_HI;
            end
            ST_FIX_HI: begin
                cmd.key = hi_reg + COORD_W'(1);
                cmd.val = res_acc_reg.vhi1;
                if (!top) begin
                    if (res_acc_reg.ex_hi1 && del_hi_reg) begin
                        cmd.op = OP_DEL;
                    end else if (!res_acc_reg.ex_hi1 && !del_hi_reg) begin
                        cmd.op = OP_INS;
                    end
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            go_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            go_reg    <= (state_reg == ST_IDLE) && s_tvalid;
            if (state_reg == ST_DONE && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            act_reg  <= s_tuser;
            lo_reg   <= in_lo;
            hi_reg   <= in_hi;
            diff_reg <= s_tdata[93:62];
        end
        if (state_reg == ST_SCAN && accs[CAP-1].active) begin
            res_acc_reg <= accs[CAP-1];
        end
        if (state_reg == ST_EVAL) begin
            result_reg  <= eval_result;
            status_reg  <= eval_status;
            vlo_new_reg <= res_acc_reg.vlo + diff_reg;
            del_lo_reg  <= (lo_reg != '0) && (res_acc_reg.vlo + diff_reg == res_acc_reg.vlo1);
            del_hi_reg  <= (res_acc_reg.vhi + diff_reg == res_acc_reg.vhi1);
        end
        if (state_reg == ST_DONE && (!m_tvalid_reg || m_tready)) begin
            m_data_reg <= result_reg;
            m_stat_reg <= status_reg;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAP; gi++) begin : g_cell
            entry_t left_w, right_w;
            acc_t   acc_w;
            if (gi == 0) begin : g_first
                assign left_w = '0;
                assign acc_w  = acc_start;
            end else begin : g_mid
                assign left_w = ents[gi-1];
                assign acc_w  = accs[gi-1];
            end
            if (gi == CAP - 1) begin : g_last
                assign right_w = '0;
            end else begin : g_inner
                assign right_w = ents[gi+1];
            end
            sfra_cell #(
                .ROOT (gi == 0)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .cmd       (cmd),
                .left_ent  (left_w),
                .right_ent (right_w),
                .acc_in    (acc_w),
                .ent       (ents[gi]),
                .acc_out   (accs[gi])
            );
        end
    endgenerate

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_stat_reg;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the step function range-add/min block, with a scoreboard class.
class sfra_scoreboard;
    bit [30:0] coord_q [$];
    bit [31:0] value_q [$];
    bit [31:0] exp_val [$];
    bit        exp_stat [$];
    int        errors;
    int        n_checked;
    int        n_rejected;
    int        cap;

    function new(int steps);
        cap = 2 * steps + 1;
        coord_q.push_back(31'd0);
        value_q.push_back(32'd0);
        errors = 0;
        n_checked = 0;
        n_rejected = 0;
    endfunction

    function int covering(bit [30:0] x);
        int best;
        best = 0;
        foreach (coord_q[i]) begin
            if (coord_q[i] <= x && coord_q[i] >= coord_q[best]) best = i;
        end
        return best;
    endfunction

    function int find_at(bit [30:0] x);
        foreach (coord_q[i]) begin
            if (coord_q[i] == x) return i;
        end
        return -1;
    endfunction

    function bit add_range(bit [30:0] lo, bit [30:0] hi, bit [31:0] diff);
        bit        top;
        bit [30:0] hi1;
        int        need;
        int        ix;
        bit [31:0] vlo;
        bit [31:0] vhi1;
        if (diff == 0) return 1'b0;
        top = (hi == 31'h7FFFFFFF);
        hi1 = hi + 31'd1;
        need = 0;
        if (find_at(lo) < 0) need++;
        if (!top && find_at(hi1) < 0) need++;
        if (cap - coord_q.size() < need) return 1'b1;
        vlo = value_q[covering(lo)];
        vhi1 = top ? 32'd0 : value_q[covering(hi1)];
        if (find_at(lo) < 0) begin
            coord_q.push_back(lo);
            value_q.push_back(vlo);
        end
        if (!top && find_at(hi1) < 0) begin
            coord_q.push_back(hi1);
            value_q.push_back(vhi1);
        end
        foreach (coord_q[i]) begin
            if (coord_q[i] >= lo && coord_q[i] <= hi) value_q[i] += diff;
        end
        if (!top) begin
            ix = find_at(hi1);
            if (value_q[covering(hi)] == value_q[ix]) begin
                coord_q.delete(ix);
                value_q.delete(ix);
            end
        end
        if (lo != 0) begin
            ix = find_at(lo);
            if (value_q[covering(lo - 31'd1)] == value_q[ix]) begin
                coord_q.delete(ix);
                value_q.delete(ix);
            end
        end
        return 1'b0;
    endfunction

    function void note_item(bit [1:0] action, bit [30:0] lo, bit [30:0] hi,
                            bit [31:0] diff);
        bit [31:0] res;
        bit        stat;
        res = 0;
        stat = 0;
        if (hi < lo) hi = lo;
        if (action == sfra_pkg::ACT_QUERY) begin
            res = value_q[covering(lo)];
        end else if (action == sfra_pkg::ACT_MIN) begin
            res = value_q[covering(lo)];
            foreach (coord_q[i]) begin
                if (coord_q[i] > lo && coord_q[i] <= hi &&
                    $signed(value_q[i]) < $signed(res)) res = value_q[i];
            end
        end else if (action == sfra_pkg::ACT_ADD) begin
            stat = add_range(lo, hi, diff);
            if (stat) n_rejected++;
        end
        exp_val.push_back(res);
        exp_stat.push_back(stat);
    endfunction

    function void check_result(bit [31:0] val, bit stat, longint t);
        bit [31:0] ev;
        bit        es;
        n_checked++;
        if (exp_val.size() == 0) begin
            $display("%0t: unexpected result value %h status %0d", t, val, stat);
            errors++;
            return;
        end
        ev = exp_val.pop_front();
        es = exp_stat.pop_front();
        if (ev !== val) begin
            $display("%0t: value mismatch expected %h actual %h", t, ev, val);
            errors++;
        end
        if (es !== stat) begin
            $display("%0t: status mismatch expected %0d actual %0d", t, es, stat);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import sfra_pkg::*;

    localparam int STEPS     = 32;
    localparam int LATENCY   = 2 * (2 * STEPS + 1) + 20;
    localparam int MAX_CYC   = 1500000;
    localparam int N_RANDOM  = 1250;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;

    sfra_scoreboard sb;
    longint         cycle_count = 0;
    bit             hold_off;
    bit             hold_done = 1'b0;
    int             n_sent;

    step_function_range_add_min_core #(.MAX_STEPS(STEPS)) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_item(bit [1:0] action, bit [30:0] lo, bit [30:0] hi,
                             bit [31:0] diff);
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= {2'b00, diff, hi, lo};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_item(action, lo, hi, diff);
        n_sent++;
    endtask

    task automatic send_gap();
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom, $urandom};
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.exp_val.size() != 0) @(posedge aclk);
    endtask

    function automatic bit [30:0] rand_coord(int mode);
        case (mode)
            0: return 31'($urandom_range(0, 40));
            1: return 31'($urandom_range(0, 2000));
            2: return 31'h7FFFFFFF - 31'($urandom_range(0, 3));
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic bit [31:0] rand_diff();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 32'h0;
        if (r < 6) return $urandom_range(0, 20) - 10;
        if (r == 6) return {r[0], 31'h7FFFFFFF} ^ $urandom_range(0, 1);
        return $urandom;
    endfunction

    // Receiver side: random stalls, with a long hold-off on request.
    initial begin
        int g;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off && !hold_done) begin
                m_tready <= 1'b0;
                repeat (800) @(posedge aclk);
                hold_done = 1'b1;
            end
            g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            if (g > 0) begin
                m_tready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0], $time);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYC) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int mode;
        bit [30:0] a;
        bit [30:0] b;
        sb = new(STEPS);
        hold_off = 1'b0;
        n_sent = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= ACT_QUERY;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, each action, zero diff, swapped range, top end.
        send_item(ACT_QUERY, 31'd0, 31'd0, 32'd0);
        send_item(ACT_ADD, 31'd0, 31'h7FFFFFFF, 32'h7FFFFFFF);
        send_item(ACT_QUERY, 31'h7FFFFFFF, 31'd0, 32'hFFFFFFFF);
        send_item(ACT_ADD, 31'd5, 31'd9, 32'h80000000);
        send_item(ACT_MIN, 31'd0, 31'h7FFFFFFF, 32'd0);
        send_item(ACT_ADD, 31'd5, 31'd9, 32'h80000000);
        send_item(ACT_MIN, 31'd3, 31'd20, 32'd0);
        send_item(ACT_ADD, 31'd10, 31'd4, 32'd7);
        send_item(ACT_QUERY, 31'd10, 31'd0, 32'd0);
        send_item(ACT_MIN, 31'd12, 31'd2, 32'd0);
        send_item(ACT_ADD, 31'd100, 31'd200, 32'd0);
        send_item(ACT_ADD, 31'h7FFFFFF0, 31'h7FFFFFFF, 32'd1);
        send_item(ACT_MIN, 31'h7FFFFFFE, 31'h7FFFFFFF, 32'd0);
        send_item(2'd3, 31'h55555555, 31'h2AAAAAAA, 32'hAAAAAAAA);
        send_item(ACT_ADD, 31'd0, 31'd0, 32'hFFFFFFF9);
        send_item(ACT_QUERY, 31'd1, 31'd0, 32'd0);
        // Fill the store until adds are rejected.
        for (int i = 0; i < 36; i++) begin
            send_item(ACT_ADD, 31'(1000 + 4 * i), 31'(1001 + 4 * i), 32'(i + 1));
        end
        send_item(ACT_MIN, 31'd900, 31'd2000, 32'd0);
        drain();

        hold_off = 1'b1;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 700) drain();
            if ($urandom_range(0, 199) == 0) begin
                for (int k = 0; k < 40; k++) begin
                    b = 31'($urandom_range(0, 60));
                    send_item(ACT_ADD, b, b + 31'($urandom_range(0, 2)), -32'(k + 1));
                end
            end
            mode = $urandom_range(0, 9);
            mode = (mode < 5) ? 0 : (mode < 8) ? 1 : (mode < 9) ? 2 : 3;
            a = rand_coord(mode);
            b = ($urandom_range(0, 9) == 0) ? rand_coord(3) : a + 31'($urandom_range(0, 30));
            if (mode == 2 && $urandom_range(0, 1)) b = 31'h7FFFFFFF;
            send_item(2'($urandom_range(0, 3) == 3 ? $urandom_range(0, 3)
                                                  : $urandom_range(0, 2)), a, b, rand_diff());
            if ($urandom_range(0, 4) == 0) send_gap();
        end
        drain();
        repeat (LATENCY) @(posedge aclk);
        $display("Sent %0d items, checked %0d results, %0d adds rejected as full.",
                 n_sent, sb.n_checked, sb.n_rejected);
        if (sb.errors == 0 && sb.exp_val.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
